// ===== rtl/core/lsd_pkg.sv =====
`timescale 1ns / 1ps
package lsd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = 20;
    localparam int LAG_W       = 9;
    localparam int ORDER_W     = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int STAGE_COUNT = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_LAG   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

    localparam logic [ORDER_W-1:0] ORDER_ONE = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_TWO = 2'd2;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic                 last;
        logic [ORDER_W-1:0]   order;
        logic                 emit;
        logic                 too_short;
    } tag_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff_value;
        logic                     last_res;
        logic                     too_short;
    } result_t;

endpackage

// ===== rtl/core/lsd_ram.sv =====
`timescale 1ns / 1ps
module lsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lsd_stage.sv =====
`timescale 1ns / 1ps
module lsd_stage #(
    parameter int IN_W  = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic signed [IN_W-1:0] wr_data,
    output logic signed [IN_W:0]   diff
);

    logic [IN_W-1:0]        rdata;
    logic                   byp_hit_reg;
    logic                   byp_hit_next;
    logic [IN_W-1:0]        byp_data_reg;
    logic signed [IN_W-1:0] hist;

    lsd_ram #(
        .WIDTH (IN_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // a read that collides with this cycle's write would see stale data: forward it
    assign byp_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge aclk) begin
        byp_hit_reg  <= byp_hit_next;
        byp_data_reg <= wr_data;
    end

    assign hist = byp_hit_reg ? $signed(byp_data_reg) : $signed(rdata);
    assign diff = {wr_data[IN_W-1], wr_data} - {hist[IN_W-1], hist};

endmodule

// ===== rtl/core/lsd_fifo.sv =====
`timescale 1ns / 1ps
module lsd_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  lsd_pkg::result_t                push_data,
    input  logic                            pop,
    output logic                            not_empty,
    output lsd_pkg::result_t                head,
    output logic [lsd_pkg::FIFO_CNT_W-1:0]  count
);
    import lsd_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t                entries [FIFO_DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/lagged_series_differencer.sv =====
`timescale 1ns / 1ps
// Lagged series differencer: y[t] = x[t] - x[t-lag], cascaded 1 to 3 times (order register).
// Takes one sample per clock while s_tready is high. Each pass keeps its delay line in a MAX_LAG-deep
// single-port-write RAM with a registered read, so a sample walks through a three-stage pipeline (one
// RAM read and one subtract per stage) and its result passes through the output queue before it reaches
// m_ tdata. The first order*lag samples of a series give no result; a series that ends with
// order*lag or fewer samples gives one result with tuser (too_short) set. An eight-entry output
// queue absorbs back-pressure; s_tready drops only when that queue plus the items in the
// pipeline would fill it. A configuration write restarts the series and must be issued idle.
module lagged_series_differencer #(
    parameter int MAX_LAG = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,    // [15:0] sample
    input  logic                            s_tlast,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,    // [19:0] diff_value, [23:20] zero
    output logic                            m_tlast,
    output logic                            m_tuser,    // [0] too_short
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsd_pkg::LAG_W-1:0]       cfg_data
);
    import lsd_pkg::*;

    localparam int AW     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int CW_MIN = $clog2(STAGE_COUNT * MAX_LAG + 1);
    localparam int CW     = (CW_MIN > LAG_W + 2) ? CW_MIN : LAG_W + 2;
    localparam logic [CW-1:0] MAX_LAG_C  = CW'(MAX_LAG);
    localparam logic [CW-1:0] SEEN_LIMIT = CW'(STAGE_COUNT * MAX_LAG);

    // registers
    logic [LAG_W-1:0]   lag_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      pos_next;
    logic [CW-1:0]      seen_reg;
    logic [CW-1:0]      seen_next;

    logic               s_accept;
    logic               cfg_accept;
    logic [CW-1:0]      lag_ext;
    logic [CW-1:0]      lag_eff;
    logic [CW-1:0]      lag_x2;
    logic [CW-1:0]      lag_x3;
    logic [CW-1:0]      need;
    logic [CW-1:0]      pos_inc;
    logic [ORDER_W-1:0] order_eff;
    tag_t               tag0;

    // pipeline
    logic                       v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]              pos1_reg, pos2_reg, pos3_reg;
    tag_t                       tag1_reg, tag2_reg, tag3_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W:0]   d1_2_reg, d1_3_reg;
    logic signed [SAMPLE_W+1:0] d2_3_reg;
    logic signed [SAMPLE_W:0]   d1;
    logic signed [SAMPLE_W+1:0] d2;
    logic signed [SAMPLE_W+2:0] d3;

    logic                      fifo_push;
    result_t                   fifo_in;
    result_t                   fifo_head;
    logic [FIFO_CNT_W-1:0]     fifo_count;
    logic [FIFO_CNT_W:0]       occupancy;

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // effective lag and order
    assign lag_ext   = CW'(lag_reg);
    assign lag_eff   = (lag_reg == '0) ? CW'(1) :
                       ((lag_ext > MAX_LAG_C) ? MAX_LAG_C : lag_ext);
    assign order_eff = (order_reg == '0) ? ORDER_ONE : order_reg;
    assign lag_x2    = lag_eff << 1;
    assign lag_x3    = lag_x2 + lag_eff;

    always_comb begin
        case (order_eff)
            ORDER_ONE: need = lag_eff;
            ORDER_TWO: need = lag_x2;
            default:   need = lag_x3;
        endcase
    end

    always_comb begin
        tag0.last      = s_tlast;
        tag0.order     = order_eff;
        tag0.emit      = (seen_reg >= need);
        tag0.too_short = (seen_reg < need) && s_tlast;
    end

    // advance the ring slot and the sample count
    assign pos_inc = CW'(pos_reg) + CW'(1);

    always_comb begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        if (cfg_accept) begin
            pos_next  = '0;
            seen_next = '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                pos_next  = '0;
                seen_next = '0;
            end else begin
                pos_next  = (pos_inc >= lag_eff) ? '0 : pos_inc[AW-1:0];
                seen_next = (seen_reg < SEEN_LIMIT) ? seen_reg + CW'(1) : seen_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg   <= LAG_W'(1);
            order_reg <= ORDER_ONE;
            pos_reg   <= '0;
            seen_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (cfg_index)
                    REG_LAG:   lag_reg   <= cfg_data;
                    REG_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                    default:   lag_reg   <= lag_reg;
                endcase
            end
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            v1_reg   <= s_accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        pos1_reg <= pos_reg;
        tag1_reg <= tag0;
        x1_reg   <= $signed(s_tdata);
        pos2_reg <= pos1_reg;
        tag2_reg <= tag1_reg;
        d1_2_reg <= d1;
        pos3_reg <= pos2_reg;
        tag3_reg <= tag2_reg;
        d1_3_reg <= d1_2_reg;
        d2_3_reg <= d2;
    end

    lsd_stage #(.IN_W(SAMPLE_W), .DEPTH(MAX_LAG)) u_stage_one (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (pos_reg),
        .wr_en   (v1_reg),
        .wr_addr (pos1_reg),
        .wr_data (x1_reg),
        .diff    (d1)
    );

    lsd_stage #(.IN_W(SAMPLE_W + 1), .DEPTH(MAX_LAG)) u_stage_two (
        .aclk    (aclk),
        .rd_en   (v1_reg),
        .rd_addr (pos1_reg),
        .wr_en   (v2_reg),
        .wr_addr (pos2_reg),
        .wr_data (d1_2_reg),
        .diff    (d2)
    );

    lsd_stage #(.IN_W(SAMPLE_W + 2), .DEPTH(MAX_LAG)) u_stage_three (
        .aclk    (aclk),
        .rd_en   (v2_reg),
        .rd_addr (pos2_reg),
        .wr_en   (v3_reg),
        .wr_addr (pos3_reg),
        .wr_data (d2_3_reg),
        .diff    (d3)
    );

    // select the pass that matches the order, drop the value on a short series
    always_comb begin
        fifo_in.last_res  = tag3_reg.last;
        fifo_in.too_short = tag3_reg.too_short;
        if (tag3_reg.too_short) begin
            fifo_in.diff_value = '0;
        end else begin
            case (tag3_reg.order)
                ORDER_ONE: fifo_in.diff_value = DIFF_W'(d1_3_reg);
                ORDER_TWO: fifo_in.diff_value = DIFF_W'(d2_3_reg);
                default:   fifo_in.diff_value = DIFF_W'(d3);
            endcase
        end
    end

    assign fifo_push = v3_reg && (tag3_reg.emit || tag3_reg.too_short);

    lsd_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (fifo_in),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (fifo_head),
        .count     (fifo_count)
    );

    // hold a slot in the queue for every item still in the pipeline
    assign occupancy = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(v1_reg)
                     + (FIFO_CNT_W + 1)'(v2_reg) + (FIFO_CNT_W + 1)'(v3_reg);
    assign s_tready  = (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

    assign m_tdata = {{(24 - DIFF_W){1'b0}}, fifo_head.diff_value};
    assign m_tlast = fifo_head.last_res;
    assign m_tuser = fifo_head.too_short;

    a_series_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (seen_reg == '0 && pos_reg == '0))
        else $error("series state not cleared after last sample");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW'(pos_reg) < lag_eff))
        else $error("ring slot beyond effective lag");

    a_short_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("too_short result not marked last");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule
